// ----- hw/rtl/uraf_pkg.sv -----
// Shared types, constants and helpers for the radix ASCII formatter.
// No dependencies; every other file of the formatter imports this package.
`default_nettype none

package uraf_pkg;

  localparam int VALUE_BITS = 16;
  localparam int KIND_W     = 2;
  localparam int PORT_W     = 3;
  localparam int CHAR_W     = 8;

  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int HEX_W      = HEX_DIGITS * 4;
  localparam int BCD_DIGITS = (VALUE_BITS * 302) / 1000 + 1;
  localparam int BCD_W      = BCD_DIGITS * 4;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO     = 8'd48;
  localparam logic [CHAR_W-1:0] HEX_LETTER_GAP = 8'd7;
  localparam logic [CHAR_W-1:0] CHAR_CR        = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF        = 8'd10;
  localparam logic [PORT_W-1:0] CRLF_PORT      = 3'd0;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR = 2'd0,
    KIND_BIN  = 2'd1,
    KIND_DEC  = 2'd2,
    KIND_HEX  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_CR   = 2'd1,
    SEL_LF   = 2'd2
  } emit_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_CONV = 3'd1,
    ST_SKIP = 3'd2,
    ST_EMIT = 3'd3,
    ST_CR   = 3'd4,
    ST_LF   = 3'd5
  } state_t;

  typedef struct packed {
    logic      load;
    logic      dd_step;
    logic      skip;
    logic      emit;
    emit_sel_t sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  cnt_one;
    logic  top_zero;
    logic  out_free;
  } dp_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d);
    logic [CHAR_W-1:0] base;
    base = ASCII_ZERO + {4'b0000, d};
    if (d > 4'd9) begin
      return base + HEX_LETTER_GAP;
    end
    return base;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/uraf_in_if.sv -----
// Input channel of the radix ASCII formatter: valid/ready plus value, format and port.
// Depends on uraf_pkg.
`default_nettype none

interface uraf_in_if import uraf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [KIND_W-1:0]     kind;
  logic [PORT_W-1:0]     port;

  modport source (output valid, output value, output kind, output port, input ready);
  modport sink   (input valid, input value, input kind, input port, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/uraf_out_if.sv -----
// Result channel of the radix ASCII formatter: valid/ready plus one character.
// Depends on uraf_pkg.
`default_nettype none

interface uraf_out_if import uraf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic [PORT_W-1:0] dest_port;
  logic              last;

  modport source (output valid, output ascii_char, output dest_port, output last,
                  input ready);
  modport sink   (input valid, input ascii_char, input dest_port, input last,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/uraf_dp.sv -----
// Datapath: holds the request, runs the binary to BCD shift-add-3 steps, shifts
// digits out and owns the output register. Depends on uraf_pkg and both interfaces.
`default_nettype none

module uraf_dp import uraf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  uraf_in_if.sink      in_chan,
  uraf_out_if.source   out_chan,
  input  wire dp_cmd_t cmd,
  output dp_stat_t     stat
);

  logic [HEX_W-1:0]  val_r,  val_nxt;
  logic [BCD_W-1:0]  bcd_r,  bcd_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  kind_t             kind_r, kind_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r,  out_char_nxt;
  logic [PORT_W-1:0] out_port_r,  out_port_nxt;
  logic              out_last_r,  out_last_nxt;

  logic [BCD_W-1:0]  bcd_adj;
  logic [3:0]        top_dig;
  logic [CHAR_W-1:0] data_char;
  logic              cnt_one;
  kind_t             in_kind;
  logic [HEX_W-1:0]  in_right;
  logic [HEX_W-1:0]  in_left;

  assign in_kind  = kind_t'(in_chan.kind);
  assign in_right = HEX_W'(in_chan.value);
  assign in_left  = HEX_W'(in_chan.value) << (HEX_W - VALUE_BITS);
  assign cnt_one  = (cnt_r == CNT_W'(1));
  assign top_dig  = (kind_r == KIND_DEC) ? bcd_r[BCD_W-1 -: 4] : val_r[HEX_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                    : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    case (kind_r)
      KIND_CHAR: data_char = val_r[CHAR_W-1:0];
      KIND_BIN:  data_char = ASCII_ZERO + {7'b0000000, val_r[HEX_W-1]};
      default:   data_char = digit_to_ascii(top_dig);
    endcase
  end

  always_comb begin
    val_nxt       = val_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    kind_nxt      = kind_r;
    port_nxt      = port_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_port_nxt  = out_port_r;
    out_last_nxt  = out_last_r;

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.load) begin
      kind_nxt = in_kind;
      port_nxt = in_chan.port;
      bcd_nxt  = '0;
      case (in_kind)
        KIND_CHAR: begin
          val_nxt = in_right;
          cnt_nxt = CNT_W'(1);
        end
        KIND_BIN: begin
          val_nxt = in_left;
          cnt_nxt = CNT_W'(VALUE_BITS);
        end
        KIND_DEC: begin
          val_nxt = in_left;
          cnt_nxt = CNT_W'(VALUE_BITS);
        end
        default: begin
          val_nxt = in_right;
          cnt_nxt = CNT_W'(HEX_DIGITS);
        end
      endcase
    end else if (cmd.dd_step) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], val_r[HEX_W-1]};
      val_nxt = val_r << 1;
      cnt_nxt = cnt_one ? CNT_W'(BCD_DIGITS) : cnt_r - CNT_W'(1);
    end else if (cmd.skip) begin
      if (kind_r == KIND_DEC) begin
        bcd_nxt = bcd_r << 4;
      end else begin
        val_nxt = val_r << 4;
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end else if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = cmd.last;
      case (cmd.sel)
        SEL_CR: begin
          out_char_nxt = CHAR_CR;
          out_port_nxt = CRLF_PORT;
        end
        SEL_LF: begin
          out_char_nxt = CHAR_LF;
          out_port_nxt = CRLF_PORT;
        end
        default: begin
          out_char_nxt = data_char;
          out_port_nxt = port_r;
          cnt_nxt      = cnt_r - CNT_W'(1);
          case (kind_r)
            KIND_BIN: val_nxt = val_r << 1;
            KIND_DEC: bcd_nxt = bcd_r << 4;
            KIND_HEX: val_nxt = val_r << 4;
            default:  val_nxt = val_r;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    kind_r     <= kind_nxt;
    port_r     <= port_nxt;
    out_char_r <= out_char_nxt;
    out_port_r <= out_port_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.ascii_char = out_char_r;
  assign out_chan.dest_port  = out_port_r;
  assign out_chan.last       = out_last_r;

  assign stat.kind     = kind_r;
  assign stat.cnt_one  = cnt_one;
  assign stat.top_zero = (top_dig == 4'd0);
  assign stat.out_free = !out_valid_r || out_chan.ready;

endmodule

`default_nettype wire

// ----- hw/rtl/uraf_ctrl.sv -----
// Controller state machine: accepts a request and sequences conversion, zero
// skipping, digit output and CR LF. Depends on uraf_pkg and uraf_in_if.
`default_nettype none

module uraf_ctrl import uraf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  uraf_in_if.sink       in_chan,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          cmd.load = 1'b1;
          case (kind_t'(in_chan.kind))
            KIND_DEC: state_nxt = ST_CONV;
            KIND_HEX: state_nxt = ST_SKIP;
            default:  state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_CONV: begin
        cmd.dd_step = 1'b1;
        if (stat.cnt_one) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat.top_zero && !stat.cnt_one) begin
          cmd.skip = 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_DATA;
          cmd.last = stat.cnt_one && (stat.kind == KIND_DEC);
          if (stat.cnt_one) begin
            state_nxt = (stat.kind == KIND_DEC) ? ST_IDLE : ST_CR;
          end
        end
      end
      ST_CR: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_CR;
          state_nxt = ST_LF;
        end
      end
      ST_LF: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_LF;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_chan.ready = in_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/uint16_radix_ascii_formatter_core.sv -----
// Sequence: a request is taken in idle; char and binary then go straight to digit output,
// hex first skips leading zero digits, and decimal first runs the 16 shift-add-3 steps of
// the BCD converter and then skips leading zeros. Char, binary and hex runs end in CR LF.
// Throughput: one character per cycle from the output register while the receiver is ready;
// a new request is taken only once the previous run's last character has been registered.
// Reset: synchronous active-low rst_n empties the output register and idles the FSM.
`default_nettype none

module uint16_radix_ascii_formatter_core import uraf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  uraf_in_if.sink    in_chan,
  uraf_out_if.source out_chan
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  uraf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .stat    (stat),
    .cmd     (cmd)
  );

  uraf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/uraf_checker.sv -----
// Port-level checker for the radix ASCII formatter, bound to the top level.
// Depends on uraf_pkg and uint16_radix_ascii_formatter_core.
`default_nettype none

module uraf_checker import uraf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CHAR_W-1:0] out_ascii_char,
  input wire logic [PORT_W-1:0] out_dest_port,
  input wire logic              out_last
);

  localparam logic [CHAR_W-1:0] ASCII_NINE = 8'd57;

  // A stalled character must stay in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ascii_char) &&
      $stable(out_dest_port) && $stable(out_last))
    else $error("result changed while stalled");

  // One request at a time: ready drops right after an accept.
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request was taken");

  // A run ends either with LF on port 0 or with a decimal digit.
  a_last_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |->
      (out_ascii_char == CHAR_LF && out_dest_port == CRLF_PORT) ||
      (out_ascii_char >= ASCII_ZERO && out_ascii_char <= ASCII_NINE))
    else $error("run ended on an unexpected character");

  // The block becomes ready again only once the final character is registered.
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(in_ready) |-> out_valid && out_last)
    else $error("ready returned before the run was complete");

endmodule

bind uint16_radix_ascii_formatter_core uraf_checker u_uraf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_ascii_char (out_chan.ascii_char),
  .out_dest_port  (out_chan.dest_port),
  .out_last       (out_chan.last)
);

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for uint16_radix_ascii_formatter_core: sends format requests and
// checks every emitted character against a predictor of the expected character run.
// Depends on uraf_pkg, uraf_in_if, uraf_out_if and the formatter core RTL.
`default_nettype none

module testbench;
  import uraf_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [PORT_W-1:0] port;
    logic              last;
  } char_rec_t;

  logic clk = 1'b0;
  logic rst_n;

  uraf_in_if  in_bus ();
  uraf_out_if out_bus ();

  uint16_radix_ascii_formatter_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus.sink),
    .out_chan (out_bus.source)
  );

  char_rec_t expected_chars[$];
  int        fail_count = 0;
  int        request_count = 0;
  int        char_count = 0;
  int        kind_count[4] = '{0, 0, 0, 0};
  int        hold_cycles = 0;
  int        held_total = 0;
  bit        sender_gaps = 1'b1;
  bit        receiver_stalls = 1'b1;

  always #4 clk = ~clk;

  initial begin
    #4_800_000;
    $display("uint16_radix_ascii_formatter_core: mismatch");
    $finish;
  end

  function automatic void push_char(logic [CHAR_W-1:0] ch, logic [PORT_W-1:0] port);
    char_rec_t rec;
    rec.ch   = ch;
    rec.port = port;
    rec.last = 1'b0;
    expected_chars.push_back(rec);
  endfunction

  function automatic void predict_chars(logic [VALUE_BITS-1:0] value, kind_t kind,
                                        logic [PORT_W-1:0] port);
    logic [3:0]            digits[$];
    logic [VALUE_BITS-1:0] rest;
    int                    base;
    rest = value;
    case (kind)
      KIND_CHAR: begin
        push_char(value[7:0], port);
      end
      KIND_BIN: begin
        for (int i = VALUE_BITS - 1; i >= 0; i--) begin
          push_char(ASCII_ZERO + {7'd0, value[i]}, port);
        end
      end
      default: begin
        base = (kind == KIND_HEX) ? 16 : 10;
        do begin
          digits.push_front(4'(rest % base));
          rest = rest / base;
        end while (rest != 0);
        foreach (digits[i]) begin
          push_char(ASCII_ZERO + {4'd0, digits[i]}
                    + ((digits[i] > 4'd9) ? HEX_LETTER_GAP : 8'd0), port);
        end
      end
    endcase
    if (kind != KIND_DEC) begin
      push_char(CHAR_CR, CRLF_PORT);
      push_char(CHAR_LF, CRLF_PORT);
    end
    expected_chars[expected_chars.size() - 1].last = 1'b1;
  endfunction

  task automatic send_request(logic [VALUE_BITS-1:0] value, kind_t kind,
                              logic [PORT_W-1:0] port);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.value <= value;
    in_bus.kind  <= kind;
    in_bus.port  <= port;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    predict_chars(value, kind, port);
    request_count++;
    kind_count[kind]++;
  endtask

  function automatic logic [VALUE_BITS-1:0] random_value();
    int k;
    k = $urandom_range(0, VALUE_BITS - 1);
    case ($urandom_range(0, 5))
      0:       return VALUE_BITS'($urandom_range(0, 20));
      1:       return VALUE_BITS'($urandom_range(0, 255));
      2:       return VALUE_BITS'(1) << k;
      3:       return (VALUE_BITS'(1) << k) - 1'b1;
      4:       return $urandom_range(0, 1) ? '1 : '0;
      default: return VALUE_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [PORT_W-1:0] random_port();
    if ($urandom_range(0, 3) == 0) begin
      return PORT_W'($urandom_range(5, 7));
    end
    return PORT_W'($urandom_range(0, 4));
  endfunction

  task automatic send_random_request();
    send_request(random_value(), kind_t'($urandom_range(0, 3)), random_port());
  endtask

  // Receiver: a random stall before each character, or a long hold when one is requested.
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        held_total += hold_cycles;
        hold_cycles = 0;
      end
      stall = receiver_stalls ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready) && hold_cycles == 0);
    end
  end

  always @(posedge clk) begin : check_chars
    char_rec_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      char_count++;
      if (expected_chars.size() == 0) begin
        $error("unexpected character %h on port %0d", out_bus.ascii_char, out_bus.dest_port);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_bus.ascii_char !== want.ch) begin
          $error("ascii_char: expected %h, got %h", want.ch, out_bus.ascii_char);
          fail_count++;
        end
        if (out_bus.dest_port !== want.port) begin
          $error("dest_port: expected %0d, got %0d", want.port, out_bus.dest_port);
          fail_count++;
        end
        if (out_bus.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_bus.last);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    send_request(16'h0000, KIND_CHAR, 3'd0);
    send_request(16'hAB41, KIND_CHAR, 3'd1);
    send_request(16'hFFFF, KIND_CHAR, 3'd7);
    send_request(16'h0080, KIND_CHAR, 3'd4);
    send_request(16'h0000, KIND_BIN, 3'd2);
    send_request(16'hFFFF, KIND_BIN, 3'd3);
    send_request(16'hAAAA, KIND_BIN, 3'd4);
    send_request(16'h5555, KIND_BIN, 3'd5);
    send_request(16'd0, KIND_DEC, 3'd0);
    send_request(16'd9, KIND_DEC, 3'd1);
    send_request(16'd10, KIND_DEC, 3'd2);
    send_request(16'd65535, KIND_DEC, 3'd6);
    send_request(16'd10000, KIND_DEC, 3'd1);
    send_request(16'd12345, KIND_DEC, 3'd2);
    send_request(16'h0000, KIND_HEX, 3'd0);
    send_request(16'h000F, KIND_HEX, 3'd3);
    send_request(16'h0010, KIND_HEX, 3'd4);
    send_request(16'hFFFF, KIND_HEX, 3'd1);
    send_request(16'hABCD, KIND_HEX, 3'd2);
    send_request(16'h00F0, KIND_HEX, 3'd7);
    send_request(16'h1000, KIND_HEX, 3'd5);
  endtask

  task automatic test_back_to_back();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    repeat (30) send_random_request();
  endtask

  // The output holds off while requests keep coming, so the core fills and stalls its input.
  task automatic test_output_hold();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b1;
    hold_cycles     = 300;
    repeat (24) send_random_request();
  endtask

  task automatic test_random();
    for (int blk = 0; blk < 6; blk++) begin
      sender_gaps     = (blk % 4) != 2;
      receiver_stalls = (blk % 4) != 1;
      repeat (40) send_random_request();
    end
  endtask

  initial begin
    int drain;
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.value  <= '0;
    in_bus.kind   <= KIND_CHAR;
    in_bus.port   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_back_to_back();
    test_output_hold();
    test_random();

    in_bus.valid <= 1'b0;
    drain = 0;
    while (expected_chars.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (expected_chars.size() != 0) begin
      $error("%0d expected characters never arrived", expected_chars.size());
      fail_count++;
    end

    $display("Covered %0d requests (%0d char, %0d binary, %0d decimal, %0d hex), %0d characters.",
             request_count, kind_count[KIND_CHAR], kind_count[KIND_BIN],
             kind_count[KIND_DEC], kind_count[KIND_HEX], char_count);
    $display("Ports 0 to 7 were used, with random gaps on both sides and a %0d-cycle output hold.",
             held_total);
    if (fail_count == 0) begin
      $display("uint16_radix_ascii_formatter_core: match");
    end else begin
      $display("uint16_radix_ascii_formatter_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
